[rtl/core/skf_pkg.sv]
// Shared types, constants and fixed-point helpers for the scalar Kalman filter core.
`default_nettype none

package skf_pkg;

   localparam int unsigned REG_W   = 24;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COV_W   = 31;
   localparam int unsigned PROD_W  = 64;
   localparam int unsigned FRAC_W  = 24;

   localparam logic [REG_W-1:0] PROCESS_NOISE_RESET     = 24'd50;
   localparam logic [REG_W-1:0] MEASUREMENT_NOISE_RESET = 24'd5033;
   localparam logic [REG_W-1:0] SAMPLE_PERIOD_RESET     = 24'd167772;

   localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};

   localparam int unsigned DIV_LONG_STEPS  = 32;
   localparam int unsigned DIV_SHORT_STEPS = 24;
   localparam int unsigned DIV_COUNT_W     = $clog2(DIV_LONG_STEPS + 1);

   typedef enum logic [1:0] {
      CSR_PROCESS_NOISE     = 2'd0,
      CSR_MEASUREMENT_NOISE = 2'd1,
      CSR_SAMPLE_PERIOD     = 2'd2
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_PREDICT = 1'b0,
      CMD_CORRECT = 1'b1
   } command_type;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_PRED_MUL  = 11'b000_0000_0010,
      ST_PRED_ADD  = 11'b000_0000_0100,
      ST_CORR_NU   = 11'b000_0000_1000,
      ST_CORR_MUL1 = 11'b000_0001_0000,
      ST_DIV1_GO   = 11'b000_0010_0000,
      ST_DIV1_RUN  = 11'b000_0100_0000,
      ST_CORR_MUL2 = 11'b000_1000_0000,
      ST_DIV2_GO   = 11'b001_0000_0000,
      ST_DIV2_RUN  = 11'b010_0000_0000,
      ST_DONE      = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic start;
      logic short_mode;
   } div_ctrl_type;

   function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
      logic [DATA_W-1:0] m;
      m = v[DATA_W-1] ? (~v + 32'd1) : v;
      return m;
   endfunction

   function automatic logic signed [DATA_W+1:0] apply_sign(input logic [DATA_W-1:0] m,
                                                           input logic neg);
      logic signed [DATA_W+1:0] e;
      e = $signed({2'b00, m});
      return neg ? -e : e;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
      logic signed [DATA_W-1:0] r;
      if ((v[DATA_W+1:DATA_W-1] == 3'b000) || (v[DATA_W+1:DATA_W-1] == 3'b111)) begin
         r = v[DATA_W-1:0];
      end else if (v[DATA_W+1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/skf_channels.sv]
// Valid/ready channel interfaces for the filter request and response transactions.
`default_nettype none

interface skf_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface skf_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] estimate;
   logic [30:0] covariance;
   logic [31:0] innovation;
   logic [31:0] innovation_cov;

   modport source (output valid, output kind, output estimate, output covariance,
                   output innovation, output innovation_cov, input ready);
   modport sink   (input valid, input kind, input estimate, input covariance,
                   input innovation, input innovation_cov, output ready);
endinterface

`default_nettype wire

[rtl/core/scalar_kalman_filter_core.sv]
// Scalar Kalman filter core: sequencer around a shared multiplier and iterative divider.
// Predict transaction: one multiply, one add, then the response registers from ST_DONE.
// Correct transaction: the divider produces 32 quotient bits for the gain correction
// plus 24 for the covariance update, one bit per cycle; no divides when S is 0.
// One transaction in flight; the next is accepted the cycle after the response registers.
// Synchronous active-high reset returns to idle, zeroes x and P, reloads CSR defaults.
`default_nettype none

module scalar_kalman_filter_core
   import skf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   skf_req_if.sink             req_if,
   skf_rsp_if.source           rsp_if,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [REG_W-1:0]    csr_wr_data
);

   state_type                  state_ff, state_in;
   logic [REG_W-1:0]           q_ff, q_in;
   logic [REG_W-1:0]           r_ff, r_in;
   logic [REG_W-1:0]           ts_ff, ts_in;
   logic signed [DATA_W-1:0]   x_ff, x_in;
   logic [COV_W-1:0]           p_ff, p_in;
   logic                       cmd_ff, cmd_in;
   logic signed [DATA_W-1:0]   val_ff, val_in;
   logic signed [DATA_W-1:0]   nu_ff, nu_in;
   logic [DATA_W-1:0]          s_ff, s_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic signed [DATA_W-1:0]   rsp_est_ff, rsp_est_in;
   logic [COV_W-1:0]           rsp_cov_ff, rsp_cov_in;
   logic signed [DATA_W-1:0]   rsp_innov_ff, rsp_innov_in;
   logic [DATA_W-1:0]          rsp_icov_ff, rsp_icov_in;

   logic [DATA_W-1:0]          mul_a, mul_b;
   logic [PROD_W-1:0]          product;
   div_ctrl_type               div_ctrl;
   logic [PROD_W-1:0]          dividend;
   logic                       div_done;
   logic [DATA_W-1:0]          quotient;

   logic                       req_accept;
   logic [55:0]                round_sum;
   logic signed [DATA_W+1:0]   x_ext;
   logic signed [DATA_W+1:0]   val_ext;
   logic [DATA_W-1:0]          cov_sum;
   logic [DATA_W-1:0]          s_sum;

   skf_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   skf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (dividend),
      .divisor  (s_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_accept    = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.kind           = rsp_kind_ff;
   assign rsp_if.estimate       = rsp_est_ff;
   assign rsp_if.covariance     = rsp_cov_ff;
   assign rsp_if.innovation     = rsp_innov_ff;
   assign rsp_if.innovation_cov = rsp_icov_ff;

   always_comb begin
      if (state_ff == ST_PRED_MUL) begin
         mul_a = {8'h00, ts_ff};
         mul_b = abs32(val_ff);
      end else if (state_ff == ST_CORR_MUL1) begin
         mul_a = {1'b0, p_ff};
         mul_b = abs32(nu_ff);
      end else begin
         mul_a = {1'b0, p_ff};
         mul_b = {8'h00, r_ff};
      end
   end

   assign div_ctrl.start      = (state_ff == ST_DIV1_GO) || (state_ff == ST_DIV2_GO);
   assign div_ctrl.short_mode = (state_ff == ST_DIV2_GO);
   assign dividend            = product + {33'd0, s_ff[DATA_W-1:1]};

   assign round_sum = product[55:0] + 56'h80_0000;
   assign x_ext     = $signed({{2{x_ff[DATA_W-1]}}, x_ff});
   assign val_ext   = $signed({{2{val_ff[DATA_W-1]}}, val_ff});
   assign cov_sum   = {1'b0, p_ff} + {8'h00, q_ff};
   assign s_sum     = {1'b0, p_ff} + {8'h00, r_ff};

   always_comb begin
      q_in  = q_ff;
      r_in  = r_ff;
      ts_in = ts_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE:     q_in  = csr_wr_data;
            CSR_MEASUREMENT_NOISE: r_in  = csr_wr_data;
            CSR_SAMPLE_PERIOD:     ts_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      nu_in        = nu_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_cov_in   = rsp_cov_ff;
      rsp_innov_in = rsp_innov_ff;
      rsp_icov_in  = rsp_icov_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in = req_if.command;
               val_in = $signed(req_if.value);
               nu_in  = '0;
               s_in   = '0;
               state_in = (req_if.command == CMD_CORRECT) ? ST_CORR_NU : ST_PRED_MUL;
            end
         end
         ST_PRED_MUL: begin
            state_in = ST_PRED_ADD;
         end
         ST_PRED_ADD: begin
            x_in     = sat32(x_ext + apply_sign(round_sum[55:24], val_ff[DATA_W-1]));
            p_in     = cov_sum[DATA_W-1] ? COV_MAX : cov_sum[COV_W-1:0];
            state_in = ST_DONE;
         end
         ST_CORR_NU: begin
            nu_in = sat32(val_ext + x_ext);
            s_in  = s_sum;
            if (s_sum == '0) begin
               p_in     = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_CORR_MUL1;
            end
         end
         ST_CORR_MUL1: begin
            state_in = ST_DIV1_GO;
         end
         ST_DIV1_GO: begin
            state_in = ST_DIV1_RUN;
         end
         ST_DIV1_RUN: begin
            if (div_done) begin
               x_in     = sat32(x_ext - apply_sign(quotient, nu_ff[DATA_W-1]));
               state_in = ST_CORR_MUL2;
            end
         end
         ST_CORR_MUL2: begin
            state_in = ST_DIV2_GO;
         end
         ST_DIV2_GO: begin
            state_in = ST_DIV2_RUN;
         end
         ST_DIV2_RUN: begin
            if (div_done) begin
               p_in     = quotient[COV_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cmd_ff;
               rsp_est_in   = x_ff;
               rsp_cov_in   = p_ff;
               rsp_innov_in = nu_ff;
               rsp_icov_in  = s_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_ff         <= PROCESS_NOISE_RESET;
         r_ff         <= MEASUREMENT_NOISE_RESET;
         ts_ff        <= SAMPLE_PERIOD_RESET;
         x_ff         <= '0;
         p_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         ts_ff        <= ts_in;
         x_ff         <= x_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      val_ff       <= val_in;
      nu_ff        <= nu_in;
      s_ff         <= s_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_est_ff   <= rsp_est_in;
      rsp_cov_ff   <= rsp_cov_in;
      rsp_innov_ff <= rsp_innov_in;
      rsp_icov_ff  <= rsp_icov_in;
   end

   a_predict_latency: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_if.command == CMD_PREDICT)) |-> ##3 (state_ff == ST_DONE))
      else $error("predict transaction did not reach completion in three cycles");

   a_div_done_in_run: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_DIV1_RUN) || (state_ff == ST_DIV2_RUN)))
      else $error("divider finished outside a divide wait state");

   a_cov_bounded_by_r: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV2_RUN) && div_done) |=> (p_ff <= {7'b0, r_ff}))
      else $error("corrected covariance exceeds measurement noise");

endmodule

`default_nettype wire

[rtl/core/skf_mul.sv]
// Shared 32x32 unsigned multiplier with a registered product.
`default_nettype none

module skf_mul
   import skf_pkg::*;
(
   input  logic                clock,
   input  logic [DATA_W-1:0]   op_a,
   input  logic [DATA_W-1:0]   op_b,
   output logic [PROD_W-1:0]   product
);

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

`default_nettype wire

[rtl/core/skf_div.sv]
// Iterative restoring divider, one quotient bit per cycle, 32 or 24 quotient bits.
`default_nettype none

module skf_div
   import skf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_ctrl_type        ctrl,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [DATA_W-1:0]   divisor,
   output logic                done,
   output logic [DATA_W-1:0]   quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_COUNT_W-1:0]   count_ff, count_in;
   logic [DATA_W-1:0]        rem_ff, rem_in;
   logic [DATA_W-1:0]        low_ff, low_in;
   logic [DATA_W-1:0]        quot_ff, quot_in;
   logic [DATA_W-1:0]        divisor_ff, divisor_in;

   logic [DATA_W:0]          rem_shift;
   logic [DATA_W+1:0]        diff;
   logic                     fits;

   assign rem_shift = {rem_ff, low_ff[DATA_W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign fits      = ~diff[DATA_W+1];

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (ctrl.start) begin
         busy_in    = 1'b1;
         divisor_in = divisor;
         quot_in    = '0;
         if (ctrl.short_mode) begin
            count_in = DIV_COUNT_W'(DIV_SHORT_STEPS);
            rem_in   = dividend[55:24];
            low_in   = {dividend[23:0], 8'h00};
         end else begin
            count_in = DIV_COUNT_W'(DIV_LONG_STEPS);
            rem_in   = dividend[63:32];
            low_in   = dividend[31:0];
         end
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
         low_in   = {low_ff[DATA_W-2:0], 1'b0};
         quot_in  = {quot_ff[DATA_W-2:0], fits};
         count_in = count_ff - DIV_COUNT_W'(1);
         if (count_ff == DIV_COUNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire
